[rtl/fzagg_pkg.sv]
// Shared types, constants and helpers of the fuzzy five-term aggregation block.
package fzagg_pkg;

    // Default number of triangular terms.
    localparam int NUM_TERMS_DEF = 5;

    // Number of truth degree registers; terms beyond these use a truth of one.
    localparam int TRUTH_REGS = 5;

    // Q1.15 value of one.
    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // Quotient bits of the membership fraction and bits resolved per divider stage.
    localparam int QBITS = 15;
    localparam int DIV_STEP_BITS = 3;

    // Segment index width, wide enough for any supported term count.
    localparam int TERM_IDX_W = 4;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRUTH_0 = 3'd2;

    // Per-item side information carried along the divider.
    typedef struct packed {
        logic [TERM_IDX_W-1:0] seg;
        logic                  low;
        logic                  high;
        logic                  invalid;
        logic [2:0]            nearest;
    } t_side;

    // A truth degree above one acts as one.
    function automatic logic [15:0] truth_clip(input logic [15:0] t);
        logic [15:0] v;
        v = (t > ONE_Q15) ? ONE_Q15 : t;
        return v;
    endfunction

endpackage

[rtl/fuzzy_five_term_aggregate.sv]
// Top level of the fuzzy term aggregation pipeline.
//
// Channel  Dir  Handshake                   Beat contents (low bit up)
// s_*      in   s_tvalid / s_tready         s_tdata: sample[15:0]
// m_*      out  m_tvalid / m_tready         m_tdata: aggregate[15:0], nearest_term[18:16],
//                                           zero[23:19]; m_tuser: range_invalid
// apb      in   psel, penable, pwrite       registers at 4*i: range_min, range_max,
//                                           truth_degree_0..4
//
// One beat is accepted per cycle while s_tready is high; a sample passes 3 front stages,
// 5 divider stages resolving 3 quotient bits each and 1 output stage.
// Reset clears every valid bit and loads the register reset values; no clearing pass.
// While an output beat waits, the whole pipeline holds and s_tready drops; bubbles
// move forward whenever the output register is empty or being taken.
module fuzzy_five_term_aggregate #(
    parameter int NUM_TERMS = fzagg_pkg::NUM_TERMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // sample[15:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // aggregate, nearest_term, zeros
    output logic                              m_tuser,   // range_invalid
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fzagg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fzagg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fzagg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import fzagg_pkg::*;

    logic signed [15:0] w_range_min;
    logic signed [15:0] w_range_max;
    logic [15:0]        w_truth [TRUTH_REGS];
    logic               w_en;

    logic               w_f_valid;
    logic [15:0]        w_f_rem;
    logic [15:0]        w_f_den;
    t_side              w_f_side;

    logic               w_d_valid;
    logic [QBITS-1:0]   w_d_quo;
    logic [15:0]        w_d_rem;
    t_side              w_d_side;

    logic [15:0]        w_agg;
    logic [2:0]         w_near;
    logic               w_inv;

    // Pipeline advances when the output register is free or being taken.
    assign w_en     = !m_tvalid || m_tready;
    assign s_tready = w_en;

    fzagg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_range_min (w_range_min),
        .o_range_max (w_range_max),
        .o_truth     (w_truth)
    );

    fzagg_front #(
        .NUM_TERMS (NUM_TERMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (s_tvalid),
        .i_sample    (s_tdata),
        .i_range_min (w_range_min),
        .i_range_max (w_range_max),
        .o_valid     (w_f_valid),
        .o_rem       (w_f_rem),
        .o_den       (w_f_den),
        .o_side      (w_f_side)
    );

    fzagg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_rem   (w_f_rem),
        .i_den   (w_f_den),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .o_quo   (w_d_quo),
        .o_rem   (w_d_rem),
        .o_side  (w_d_side)
    );

    fzagg_back #(
        .NUM_TERMS (NUM_TERMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_d_valid),
        .i_quo       (w_d_quo),
        .i_rem       (w_d_rem),
        .i_side      (w_d_side),
        .i_truth     (w_truth),
        .o_valid     (m_tvalid),
        .o_aggregate (w_agg),
        .o_nearest   (w_near),
        .o_invalid   (w_inv)
    );

    // Output beat packing.
    assign m_tdata = {5'b0, w_near, w_agg};
    assign m_tuser = w_inv;

endmodule

[rtl/fzagg_cfg.sv]
// Configuration register file with its APB-style access port.
module fzagg_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fzagg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fzagg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fzagg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic signed [15:0]                o_range_min,
    output logic signed [15:0]                o_range_max,
    output logic [15:0]                       o_truth [fzagg_pkg::TRUTH_REGS]
);
    import fzagg_pkg::*;

    logic signed [15:0]   r_range_min;
    logic signed [15:0]   r_range_max;
    logic [15:0]          r_truth [TRUTH_REGS];
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    // Registers sit on word addresses; the low address bits are ignored.
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Range registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= 16'sh8000;
            r_range_max <= 16'sh7FFF;
        end else if (w_wr) begin
            if (w_idx == REG_RANGE_MIN) begin
                r_range_min <= pwdata[15:0];
            end
            if (w_idx == REG_RANGE_MAX) begin
                r_range_max <= pwdata[15:0];
            end
        end
    end

    // Truth degree registers; writes to unknown indexes are dropped.
    for (genvar g = 0; g < TRUTH_REGS; g++) begin : g_truth
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_truth[g] <= ONE_Q15;
            end else if (w_wr && (w_idx == REG_TRUTH_0 + REG_IDX_W'(g))) begin
                r_truth[g] <= pwdata[15:0];
            end
        end
    end

    // Read data mux.
    always_comb begin
        prdata = '0;
        if (w_idx == REG_RANGE_MIN) begin
            prdata = APB_DATA_W'(r_range_min);
        end else if (w_idx == REG_RANGE_MAX) begin
            prdata = APB_DATA_W'(r_range_max);
        end else begin
            for (int i = 0; i < TRUTH_REGS; i++) begin
                if (w_idx == REG_TRUTH_0 + REG_IDX_W'(i)) begin
                    prdata = APB_DATA_W'(r_truth[i]);
                end
            end
        end
    end

    assign o_range_min = r_range_min;
    assign o_range_max = r_range_max;
    assign o_truth     = r_truth;

endmodule

[rtl/fzagg_front.sv]
// Front stages: scaled offset, segment search and remainder within the segment.
module fzagg_front #(
    parameter int NUM_TERMS = fzagg_pkg::NUM_TERMS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [15:0]  i_sample,
    input  logic signed [15:0]  i_range_min,
    input  logic signed [15:0]  i_range_max,
    output logic                o_valid,
    output logic [15:0]         o_rem,
    output logic [15:0]         o_den,
    output fzagg_pkg::t_side    o_side
);
    import fzagg_pkg::*;

    localparam int DW = 17 + $clog2(NUM_TERMS);
    localparam int PW = DW - 1;
    localparam int KW = $clog2(NUM_TERMS);

    // Stage A: D = (N-1)*(x-min) and d = max-min.
    logic signed [16:0]   w_xm;
    logic signed [16:0]   w_dr;
    logic signed [DW-1:0] n_a_base;
    logic signed [DW-1:0] r_a_base;
    logic [15:0]          r_a_den;
    logic                 r_a_inv;
    logic                 r_a_valid;

    assign w_xm     = 17'(i_sample) - 17'(i_range_min);
    assign w_dr     = 17'(i_range_max) - 17'(i_range_min);
    assign n_a_base = DW'(w_xm) * DW'(NUM_TERMS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_base <= n_a_base;
            r_a_den  <= w_dr[15:0];
            r_a_inv  <= w_dr[16] || (w_dr == '0);
        end
    end

    // Stage B: count the centers of terms 1 to N-1 at or below D to find the segment.
    logic [KW-1:0]        n_b_seg;
    logic                 n_b_high;
    logic signed [DW-1:0] r_b_base;
    logic [15:0]          r_b_den;
    logic [KW-1:0]        r_b_seg;
    logic                 r_b_low;
    logic                 r_b_high;
    logic                 r_b_inv;
    logic                 r_b_valid;

    always_comb begin
        logic [PW-1:0] v_prod;
        logic [PW-1:0] v_top;
        logic [KW-1:0] v_cnt;
        v_cnt = '0;
        for (int i = 1; i < NUM_TERMS; i++) begin
            v_prod = PW'(r_a_den) * PW'(i);
            if (r_a_base >= $signed({1'b0, v_prod})) begin
                v_cnt = v_cnt + 1'b1;
            end
        end
        v_top    = PW'(r_a_den) * PW'(NUM_TERMS - 1);
        n_b_seg  = v_cnt;
        n_b_high = r_a_base > $signed({1'b0, v_top});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_base <= r_a_base;
            r_b_den  <= r_a_den;
            r_b_seg  <= n_b_seg;
            r_b_low  <= r_a_base[DW-1];
            r_b_high <= n_b_high;
            r_b_inv  <= r_a_inv;
        end
    end

    // Stage C: remainder inside the segment and the nearest center.
    logic [15:0] n_c_rem;
    logic [2:0]  n_c_near;
    logic [15:0] r_c_rem;
    logic [15:0] r_c_den;
    t_side       r_c_side;
    logic        r_c_valid;

    always_comb begin
        logic [PW-1:0] v_kd;
        logic [DW-1:0] v_diff;
        logic [KW:0]   v_up;
        v_kd    = PW'(r_b_den) * PW'(r_b_seg);
        v_diff  = DW'(r_b_base - $signed({1'b0, v_kd}));
        n_c_rem = v_diff[15:0];
        if (r_b_low || r_b_high || r_b_inv) begin
            n_c_rem = '0;
        end
        v_up = {1'b0, r_b_seg} + 1'b1;
        priority if (r_b_inv || r_b_low) begin
            n_c_near = '0;
        end else if (v_up >= (KW+1)'(NUM_TERMS)) begin
            n_c_near = 3'(NUM_TERMS - 1);
        end else if ({n_c_rem, 1'b0} < {1'b0, r_b_den}) begin
            n_c_near = 3'(r_b_seg);
        end else begin
            n_c_near = 3'(v_up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_rem          <= n_c_rem;
            r_c_den          <= r_b_den;
            r_c_side.seg     <= TERM_IDX_W'(r_b_seg);
            r_c_side.low     <= r_b_low;
            r_c_side.high    <= r_b_high;
            r_c_side.invalid <= r_b_inv;
            r_c_side.nearest <= n_c_near;
        end
    end

    assign o_valid = r_c_valid;
    assign o_rem   = r_c_rem;
    assign o_den   = r_c_den;
    assign o_side  = r_c_side;

endmodule

[rtl/fzagg_div.sv]
// Pipelined restoring divider giving floor(r * 2^15 / d) and its remainder.
module fzagg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [15:0]               i_rem,
    input  logic [15:0]               i_den,
    input  fzagg_pkg::t_side          i_side,
    output logic                      o_valid,
    output logic [fzagg_pkg::QBITS-1:0] o_quo,
    output logic [15:0]               o_rem,
    output fzagg_pkg::t_side          o_side
);
    import fzagg_pkg::*;

    localparam int NSTG = (QBITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

    logic [15:0]      r_rem  [NSTG];
    logic [QBITS-1:0] r_quo  [NSTG];
    logic [15:0]      r_den  [NSTG];
    t_side            r_side [NSTG];
    logic             r_valid [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [15:0]      w_rem;
        logic [QBITS-1:0] w_quo;
        logic [15:0]      w_den;
        t_side            w_side;
        logic             w_valid;
        logic [15:0]      n_rem;
        logic [QBITS-1:0] n_quo;

        // Stage input: the module ports or the previous stage.
        if (s == 0) begin : g_first
            assign w_rem   = i_rem;
            assign w_quo   = '0;
            assign w_den   = i_den;
            assign w_side  = i_side;
            assign w_valid = i_valid;
        end else begin : g_next
            assign w_rem   = r_rem[s-1];
            assign w_quo   = r_quo[s-1];
            assign w_den   = r_den[s-1];
            assign w_side  = r_side[s-1];
            assign w_valid = r_valid[s-1];
        end

        // A few shift-compare-subtract steps; the partial remainder stays below d.
        always_comb begin
            logic [16:0]      v_sh;
            logic [15:0]      v_rem;
            logic [QBITS-1:0] v_quo;
            v_rem = w_rem;
            v_quo = w_quo;
            for (int j = 0; j < DIV_STEP_BITS; j++) begin
                if (s * DIV_STEP_BITS + j < QBITS) begin
                    v_sh = {v_rem, 1'b0};
                    if (v_sh >= {1'b0, w_den}) begin
                        v_sh  = v_sh - {1'b0, w_den};
                        v_quo = {v_quo[QBITS-2:0], 1'b1};
                    end else begin
                        v_quo = {v_quo[QBITS-2:0], 1'b0};
                    end
                    v_rem = v_sh[15:0];
                end
            end
            n_rem = v_rem;
            n_quo = v_quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_den[s]  <= w_den;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_quo   = r_quo[NSTG-1];
    assign o_rem   = r_rem[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

[rtl/fzagg_back.sv]
// Back stage: memberships of the two active terms, truth clipping, max, output register.
module fzagg_back #(
    parameter int NUM_TERMS = fzagg_pkg::NUM_TERMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [fzagg_pkg::QBITS-1:0] i_quo,
    input  logic [15:0]                 i_rem,
    input  fzagg_pkg::t_side            i_side,
    input  logic [15:0]                 i_truth [fzagg_pkg::TRUTH_REGS],
    output logic                        o_valid,
    output logic [15:0]                 o_aggregate,
    output logic [2:0]                  o_nearest,
    output logic                        o_invalid
);
    import fzagg_pkg::*;

    // Clipped truth per term, one extra entry for the term above the top segment.
    logic [15:0] w_tr [NUM_TERMS+1];

    for (genvar g = 0; g <= NUM_TERMS; g++) begin : g_tr
        if (g < TRUTH_REGS) begin : g_reg
            assign w_tr[g] = truth_clip(i_truth[g]);
        end else begin : g_one
            assign w_tr[g] = ONE_Q15;
        end
    end

    // Lower term gets 1 - r/d rounded down, upper term gets r/d rounded down.
    logic [15:0] n_agg;

    always_comb begin
        logic [15:0]           v_tk;
        logic [15:0]           v_tk1;
        logic [15:0]           v_mk;
        logic [15:0]           v_mk1;
        logic [15:0]           v_a;
        logic [15:0]           v_b;
        logic [TERM_IDX_W-1:0] v_seg1;
        v_tk   = ONE_Q15;
        v_tk1  = ONE_Q15;
        v_seg1 = i_side.seg + 1'b1;
        for (int i = 0; i <= NUM_TERMS; i++) begin
            if (TERM_IDX_W'(i) == i_side.seg) begin
                v_tk = w_tr[i];
            end
            if (TERM_IDX_W'(i) == v_seg1) begin
                v_tk1 = w_tr[i];
            end
        end
        v_mk  = ONE_Q15 - 16'(i_quo) - 16'(i_rem != '0);
        v_mk1 = 16'(i_quo);
        v_a   = (v_tk < v_mk) ? v_tk : v_mk;
        v_b   = (v_tk1 < v_mk1) ? v_tk1 : v_mk1;
        priority if (i_side.invalid) begin
            n_agg = '0;
        end else if (i_side.low) begin
            n_agg = w_tr[0];
        end else if (i_side.high) begin
            n_agg = w_tr[NUM_TERMS-1];
        end else begin
            n_agg = (v_a > v_b) ? v_a : v_b;
        end
    end

    // Output register.
    logic        r_valid;
    logic [15:0] r_agg;
    logic [2:0]  r_near;
    logic        r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_agg  <= n_agg;
            r_near <= i_side.nearest;
            r_inv  <= i_side.invalid;
        end
    end

    assign o_valid     = r_valid;
    assign o_aggregate = r_agg;
    assign o_nearest   = r_near;
    assign o_invalid   = r_inv;

endmodule

[dv/fuzzy_five_term_aggregate_checker.sv]
// Checker that predicts and compares every result beat of the fuzzy term aggregation block.
`timescale 1ns / 1ps

module fuzzy_five_term_aggregate_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [15:0]                      i_s_tdata,    // sample[15:0]
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [23:0]                      i_m_tdata,    // aggregate[15:0], nearest_term[18:16], zero[23:19]
    input  logic                             i_m_tuser,    // range_invalid
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [fzagg_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [fzagg_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    import fzagg_pkg::*;

    localparam int TERMS = NUM_TERMS_DEF;

    typedef struct packed {
        logic [15:0] aggregate;
        logic [2:0]  nearest_term;
        logic        range_invalid;
    } fz_result_t;

    // Local copy of the register file, updated from the configuration bus.
    logic signed [15:0]   range_lo;
    logic signed [15:0]   range_hi;
    logic [15:0]          truth_deg [TRUTH_REGS];
    logic [REG_IDX_W-1:0] reg_idx;

    fz_result_t fz_result_q [$];
    fz_result_t want;
    int         fail_total = 0;
    int         checked_total = 0;
    int         pending_n = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_n;
    assign o_checked    = checked_total;

    // Membership of every term clipped by its truth degree, the max over terms, and the nearest term.
    function automatic fz_result_t eval_terms(input logic [15:0] raw);
        longint      x;
        longint      span;
        longint      base;
        longint      gap;
        longint      adist;
        longint      lower;
        int unsigned member;
        int unsigned clip;
        int unsigned best;
        int unsigned near;
        bit          seen;
        fz_result_t  r;
        r    = '0;
        x    = longint'($signed(raw));
        span = longint'(range_hi) - longint'(range_lo);
        if (span <= 0) begin
            r.range_invalid = 1'b1;
            return r;
        end
        base = longint'(TERMS - 1) * (x - longint'(range_lo));
        best = 0;
        near = TERMS - 1;
        seen = 1'b0;
        for (int i = 0; i < TERMS; i++) begin
            gap   = base - longint'(i) * span;
            adist = (gap < 0) ? -gap : gap;
            // The outer terms are shoulders that stay at one beyond their centers.
            if ((i == 0 && gap < 0) || (i == TERMS - 1 && gap > 0)) begin
                member = int'(ONE_Q15);
            end else if (adist > span) begin
                member = 0;
            end else begin
                member = int'(((span - adist) * 32768) / span);
            end
            if (i >= TRUTH_REGS) begin
                clip = int'(ONE_Q15);
            end else begin
                clip = (truth_deg[i] > ONE_Q15) ? int'(ONE_Q15) : int'(truth_deg[i]);
            end
            if (clip < member) begin
                member = clip;
            end
            if (member > best) begin
                best = member;
            end
            // The first center above the sample and the one below it bracket it.
            if (!seen && gap < 0) begin
                seen = 1'b1;
                if (i == 0) begin
                    near = 0;
                end else begin
                    lower = gap + span;
                    lower = (lower < 0) ? -lower : lower;
                    near  = (lower < adist) ? i - 1 : i;
                end
            end
        end
        r.aggregate    = best[15:0];
        r.nearest_term = near[2:0];
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
        fail_total++;
        $error("%s: expected %0d, got %0d", field, exp_v, got_v);
    endtask

    // Track register writes, queue a prediction per sample beat, check result beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            range_lo = -16'sd32768;
            range_hi = 16'sd32767;
            for (int k = 0; k < TRUTH_REGS; k++) begin
                truth_deg[k] = ONE_Q15;
            end
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = i_paddr[APB_ADDR_W-1:2];
                if (reg_idx == REG_RANGE_MIN) begin
                    range_lo = i_pwdata[15:0];
                end else if (reg_idx == REG_RANGE_MAX) begin
                    range_hi = i_pwdata[15:0];
                end else if (reg_idx >= REG_TRUTH_0 && reg_idx < REG_TRUTH_0 + TRUTH_REGS) begin
                    truth_deg[reg_idx - REG_TRUTH_0] = i_pwdata[15:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fz_result_q = {fz_result_q, eval_terms(i_s_tdata)};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (fz_result_q.size() == 0) begin
                    fail_total++;
                    $error("result beat with no sample waiting: tdata %h", i_m_tdata);
                end else begin
                    want = fz_result_q.pop_front();
                    checked_total++;
                    if (i_m_tdata[15:0] !== want.aggregate) begin
                        note_mismatch("aggregate", want.aggregate, i_m_tdata[15:0]);
                    end
                    if (i_m_tdata[18:16] !== want.nearest_term) begin
                        note_mismatch("nearest_term", 16'(want.nearest_term),
                                      16'(i_m_tdata[18:16]));
                    end
                    if (i_m_tuser !== want.range_invalid) begin
                        note_mismatch("range_invalid", 16'(want.range_invalid),
                                      16'(i_m_tuser));
                    end
                    if (i_m_tdata[23:19] !== 5'd0) begin
                        note_mismatch("tdata padding", 16'd0, 16'(i_m_tdata[23:19]));
                    end
                end
            end
        end
        pending_n = fz_result_q.size();
    end

endmodule

[dv/fuzzy_five_term_aggregate_tb.sv]
// Testbench top: clock, reset, register setup, sample and back-pressure stimulus, verdict.
`timescale 1ns / 1ps

module fuzzy_five_term_aggregate_tb;
    import fzagg_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 12;
    localparam int IDLE_PCT        = 28;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // sample[15:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // aggregate[15:0], nearest_term[18:16], zero[23:19]
    logic                  m_tuser;   // range_invalid
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending_beats;
    int checked_beats;
    int cycle_count = 0;
    int samples_sent = 0;
    int settings_used = 1;
    int cfg_lo = -32768;
    int cfg_hi = 32767;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_off_go = 1'b0;

    fuzzy_five_term_aggregate dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fuzzy_five_term_aggregate_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats),
        .o_checked    (checked_beats)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_go) begin
                hold_off_go = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= !rx_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Mostly samples inside the range and close to the term centers, the rest anywhere.
    function automatic int pick_sample();
        int span;
        int sel;
        int k;
        span = cfg_hi - cfg_lo;
        sel  = $urandom_range(0, 9);
        if (span <= 0 || sel < 4) begin
            return int'($urandom_range(0, 65535));
        end
        if (sel < 7) begin
            return clamp16(cfg_lo - 4 + int'($urandom_range(0, span + 8)));
        end
        k = $urandom_range(0, 4);
        return clamp16(cfg_lo + (k * span) / 4 + int'($urandom_range(0, 6)) - 3);
    endfunction

    // Truth degrees: zero, exactly one, above one, or anything in between.
    function automatic int pick_truth();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return 0;
        end else if (sel == 1) begin
            return 32768;
        end else if (sel == 2) begin
            return int'($urandom_range(32769, 65535));
        end
        return int'($urandom_range(0, 32768));
    endfunction

    // One sample beat; valid stays high from one beat to the next unless an idle falls between.
    task automatic send_sample(input int v);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v[15:0];
        do @(posedge i_clk); while (!s_tready);
        samples_sent++;
    endtask

    // Setup and access phase of a register write; the bus is left selected for back-to-back use.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(0, 65535)), v[15:0]};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_range(input int lo, input int hi);
        reg_write(REG_RANGE_MIN, lo);
        reg_write(REG_RANGE_MAX, hi);
        cfg_lo = lo;
        cfg_hi = hi;
        settings_used++;
    endtask

    // Stop offering samples and wait until every expected result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_beats == 0);
        @(posedge i_clk);
    endtask

    initial begin
        int lo;
        int hi;
        int span_a;
        int span_b;
        int count;

        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full 16-bit universe, every truth degree at one.
        send_sample(-32768);
        send_sample(32767);
        send_sample(0);
        send_sample(-1);
        send_sample(16383);

        // Range +-1000, one truth degree of each kind; samples on centers, midpoints and outside.
        drain();
        set_range(-1000, 1000);
        reg_write(REG_TRUTH_0, 0);
        reg_write(REG_IDX_W'(REG_TRUTH_0 + 1), 16'h4000);
        reg_write(REG_IDX_W'(REG_TRUTH_0 + 2), 16'hFFFF);
        reg_write(REG_IDX_W'(REG_TRUTH_0 + 3), 32768);
        reg_write(REG_IDX_W'(REG_TRUTH_0 + 4), 12345);
        reg_write(REG_UNUSED, 16'h1234);
        bus_release();
        send_sample(-1000);
        send_sample(-750);
        send_sample(-500);
        send_sample(-250);
        send_sample(0);
        send_sample(250);
        send_sample(500);
        send_sample(750);
        send_sample(1000);
        send_sample(-1001);
        send_sample(1001);
        send_sample(-32768);

        // Empty range, then a reversed range at the extremes.
        drain();
        set_range(5, 5);
        bus_release();
        send_sample(0);
        send_sample(5);
        drain();
        set_range(32767, -32768);
        bus_release();
        send_sample(32767);
        send_sample(-32768);

        // One-LSB ranges at both ends of the scale.
        drain();
        set_range(-32768, -32767);
        bus_release();
        send_sample(-32768);
        send_sample(32767);
        drain();
        set_range(32766, 32767);
        bus_release();
        send_sample(32766);
        send_sample(-32767);

        // Random phases, each with its own range and truth degrees.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            span_a = int'($urandom_range(0, 65535)) - 32768;
            span_b = int'($urandom_range(0, 65535)) - 32768;
            case (ph)
                0: begin
                    lo = -32768;
                    hi = 32767;
                end
                1: begin
                    lo = int'($urandom_range(0, 65535 - 12)) - 32768;
                    hi = lo + int'($urandom_range(1, 12));
                end
                3: begin
                    lo = span_a;
                    hi = span_b;
                end
                4: begin
                    lo = span_a;
                    hi = lo - int'($urandom_range(0, lo + 32768));
                end
                default: begin
                    lo = (span_a < span_b) ? span_a : span_b;
                    hi = (span_a < span_b) ? span_b : span_a;
                end
            endcase
            set_range(lo, hi);
            for (int k = 0; k < TRUTH_REGS; k++) begin
                reg_write(REG_IDX_W'(REG_TRUTH_0 + k), pick_truth());
            end
            bus_release();
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            if (ph == 3) begin
                hold_off_go = 1'b1;
            end
            count = (ph == 4) ? 100 : 290;
            repeat (count) send_sample(pick_sample());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d samples over %0d range settings, %0d result beats compared.",
                 samples_sent, settings_used, checked_beats);
        $display("Covered empty and reversed ranges, one-LSB ranges, truth degrees above one, %s",
                 "and a long output hold-off.");
        if (fail_count == 0 && pending_beats == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[fuzzy_five_term_aggregate.f]
rtl/fzagg_pkg.sv
rtl/fzagg_cfg.sv
rtl/fzagg_front.sv
rtl/fzagg_div.sv
rtl/fzagg_back.sv
rtl/fuzzy_five_term_aggregate.sv
dv/fuzzy_five_term_aggregate_checker.sv
dv/fuzzy_five_term_aggregate_tb.sv
